### hw/rtl/gms_pkg.sv
// Package for the gradient magnitude sketch pixel unit.
// Holds the transfer structs, format codes, register indexes and fixed limits.
// No dependencies.
`timescale 1ns / 1ps
package gms_pkg;

	localparam int GRAD_W     = 20;
	localparam int WORD_W     = 32;
	localparam int FMT_W      = 3;
	localparam int GAIN_W     = 10;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int ROOT_W     = GRAD_W;
	localparam int QUO_W      = 15;

	localparam logic [FMT_W-1:0] FMT_BGRA8  = 3'd0;
	localparam logic [FMT_W-1:0] FMT_BGRA16 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_VUYA8  = 3'd2;
	localparam logic [FMT_W-1:0] FMT_ARGB8  = 3'd3;
	localparam logic [FMT_W-1:0] FMT_ARGB16 = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 4'd1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd100;

	localparam logic [QUO_W-1:0] MAX8  = 15'd255;
	localparam logic [QUO_W-1:0] MAX16 = 15'd32767;

	localparam logic [15:0] CHROMA_NEUTRAL = 16'h8080;

	typedef struct packed {
		logic signed [GRAD_W-1:0] grad_vertical;
		logic signed [GRAD_W-1:0] grad_horizontal;
		logic [WORD_W-1:0]        src_word_lo;
		logic [WORD_W-1:0]        src_word_hi;
		logic                     frame_last;
	} pix_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] dst_word_lo;
		logic [WORD_W-1:0] dst_word_hi;
		logic              last_out;
	} pix_out_t;

	typedef struct packed {
		logic [WORD_W-1:0] src_lo;
		logic [WORD_W-1:0] src_hi;
		logic              last;
	} side_t;

endpackage

### hw/rtl/gms_isqrt.sv
// Pipelined floor integer square root, one result bit per register stage.
// Carries a valid bit and a sideband vector alongside. No package dependency.
`timescale 1ns / 1ps
module gms_isqrt #(
	parameter int N      = 20,
	parameter int SIDE_W = 65
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  logic [2*N-1:0]    rad_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [N-1:0]      root_out,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RW = N + 3;

	logic              vld_s  [0:N];
	logic [2*N-1:0]    rad_s  [0:N];
	logic [RW-1:0]     rem_s  [0:N];
	logic [N-1:0]      root_s [0:N];
	logic [SIDE_W-1:0] side_s [0:N];

	assign vld_s[0]  = vld_in;
	assign rad_s[0]  = rad_in;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [RW-1:0] trial;
		logic [RW-1:0] sub;
		logic          ge;

		always_comb begin
			trial = {rem_s[i][RW-3:0], rad_s[i][2*(N-1-i) +: 2]};
			sub   = {1'b0, root_s[i], 2'b01};
			ge    = trial >= sub;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[i+1]  <= rad_s[i];
			rem_s[i+1]  <= ge ? trial - sub : trial;
			root_s[i+1] <= {root_s[i][N-2:0], ge};
			side_s[i+1] <= side_s[i];
		end
	end

	assign vld_out  = vld_s[N];
	assign root_out = root_s[N];
	assign side_out = side_s[N];

endmodule

### hw/rtl/gms_cdiv.sv
// Division by a constant through reciprocal multiplication, one register stage.
// Exact for every dividend below 2**RW; carries valid and sideband. No package dependency.
`timescale 1ns / 1ps
module gms_cdiv #(
	parameter int DEN    = 100,
	parameter int RW     = 23,
	parameter int QW     = 15,
	parameter int SIDE_W = 66
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  logic [RW-1:0]     dvd_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [QW-1:0]     quo_out,
	output logic [SIDE_W-1:0] side_out
);

	localparam int SH = RW + $clog2(DEN);
	localparam int MW = RW + 1;
	localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

	logic [RW+MW-1:0]  prod;
	logic              vld_s1;
	logic [QW-1:0]     quo_s1;
	logic [SIDE_W-1:0] side_s1;

	assign prod = {{MW{1'b0}}, dvd_in} * {{RW{1'b0}}, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		quo_s1  <= prod[SH +: QW];
		side_s1 <= side_in;
	end

	assign vld_out  = vld_s1;
	assign quo_out  = quo_s1;
	assign side_out = side_s1;

endmodule

### hw/rtl/gradient_magnitude_sketch_pixel_unit.sv
// Inverted gradient magnitude sketch, one pixel per clock.
// Depends on gms_pkg, gms_isqrt and gms_cdiv.
//
// Usage:
//   Input: drive pixel_in and pulse start; a transfer happens at each edge
//   with start high and busy low. busy stays low, so a pixel may enter on
//   every clock.
//   Output: result_valid is high for exactly one cycle with pixel_out; the
//   receiver takes it at that edge and cannot hold it off.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 selects
//   pixel_format, 1 selects gain, other indexes are dropped. cfg_ready is
//   always high. Write only while no pixel is in flight.
// Pipeline from the input transfer to result_valid: the 20 stages of the
//   square root and seven single stages, namely abs, square, sum, gain
//   multiply, ceiling with clamp, the reciprocal multiply that divides by
//   DIVIDER*256, and packing. Throughput: one pixel per clock.
// Reset: arst_n clears all valid bits, format goes to BGRA8 and gain to 100.
`timescale 1ns / 1ps
module gradient_magnitude_sketch_pixel_unit #(
	parameter int DIVIDER = 100
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  gms_pkg::pix_in_t                    pixel_in,
	output logic                                result_valid,
	output gms_pkg::pix_out_t                   pixel_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gms_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import gms_pkg::*;

	localparam int  FRAC_W = 8;
	localparam int  DEN    = DIVIDER * 256;
	localparam int  DEN_W  = $clog2(DEN + 1);
	localparam int  P_W    = ROOT_W + GAIN_W;
	localparam int  DV_W   = (P_W + 1 > DEN_W + QUO_W) ? P_W + 1 : DEN_W + QUO_W;
	localparam int  SIDE_W = $bits(side_t);
	localparam int  LAT    = 3 + ROOT_W + 2 + 1 + 1;
	localparam longint LIM8_L  = longint'(DEN) * 64'd256;
	localparam longint LIM16_L = longint'(DEN) * 64'd32768;
	localparam logic [DV_W-1:0] LIM8  = DV_W'(LIM8_L);
	localparam logic [DV_W-1:0] LIM16 = DV_W'(LIM16_L);
	localparam logic [DV_W-1:0] CEIL_ADD = DV_W'(DEN - 1);

	logic [FMT_W-1:0]  fmt_q;
	logic [GAIN_W-1:0] gain_q;
	logic              fmt16;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign fmt16     = fmt_q inside {FMT_BGRA16, FMT_ARGB16};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FMT_BGRA8;
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PIXEL_FORMAT: fmt_q  <= cfg_data[FMT_W-1:0];
				CFG_GAIN:         gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [GRAD_W-1:0]      av_s1, ah_s1;
	logic [2*GRAD_W-1:0]    sqv_s2, sqh_s2, q_s3;
	logic [P_W-1:0]         p_s4;
	logic [DV_W-1:0]        pc_s5;
	logic                   clamp_s5;
	side_t                  side_s1, side_s2, side_s3, side_s4, side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		av_s1   <= pixel_in.grad_vertical[GRAD_W-1] ?
			GRAD_W'(-pixel_in.grad_vertical) : GRAD_W'(pixel_in.grad_vertical);
		ah_s1   <= pixel_in.grad_horizontal[GRAD_W-1] ?
			GRAD_W'(-pixel_in.grad_horizontal) : GRAD_W'(pixel_in.grad_horizontal);
		side_s1 <= '{src_lo: pixel_in.src_word_lo, src_hi: pixel_in.src_word_hi,
			last: pixel_in.frame_last};
		sqv_s2  <= {{GRAD_W{1'b0}}, av_s1} * {{GRAD_W{1'b0}}, av_s1};
		sqh_s2  <= {{GRAD_W{1'b0}}, ah_s1} * {{GRAD_W{1'b0}}, ah_s1};
		side_s2 <= side_s1;
		q_s3    <= sqv_s2 + sqh_s2;
		side_s3 <= side_s2;
	end

	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	logic [SIDE_W-1:0] sq_side;

	gms_isqrt #(
		.N      (ROOT_W),
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s3),
		.rad_in   (q_s3),
		.side_in  (side_s3),
		.vld_out  (sq_vld),
		.root_out (sq_root),
		.side_out (sq_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		p_s4     <= {{GAIN_W{1'b0}}, sq_root} * {{ROOT_W{1'b0}}, gain_q};
		side_s4  <= side_t'(sq_side);
		pc_s5    <= DV_W'(p_s4) + CEIL_ADD;
		clamp_s5 <= fmt16 ? (DV_W'(p_s4) + CEIL_ADD >= LIM16)
			: (DV_W'(p_s4) + CEIL_ADD >= LIM8);
		side_s5  <= side_s4;
	end

	logic                dv_vld;
	logic [QUO_W-1:0]    dv_quo;
	logic [SIDE_W:0]     dv_side;

	gms_cdiv #(
		.DEN    (DIVIDER),
		.RW     (DV_W - FRAC_W),
		.QW     (QUO_W),
		.SIDE_W (SIDE_W + 1)
	) u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s5),
		.dvd_in   (pc_s5[DV_W-1:FRAC_W]),
		.side_in  ({clamp_s5, side_s5}),
		.vld_out  (dv_vld),
		.quo_out  (dv_quo),
		.side_out (dv_side)
	);

	side_t             dv_sb;
	logic              dv_clamp;
	logic [QUO_W-1:0]  maxv, cval, grey;
	logic [7:0]        g8;
	logic [15:0]       g16;
	logic [WORD_W-1:0] lo, hi;

	always_comb begin
		dv_sb    = side_t'(dv_side[SIDE_W-1:0]);
		dv_clamp = dv_side[SIDE_W];
		maxv     = fmt16 ? MAX16 : MAX8;
		cval     = dv_clamp ? maxv : dv_quo;
		grey     = maxv - cval;
		g8       = grey[7:0];
		g16      = {1'b0, grey};
		lo       = '0;
		hi       = '0;
		case (fmt_q)
			FMT_BGRA8: begin
				lo = {dv_sb.src_lo[31:24], g8, g8, g8};
			end
			FMT_BGRA16: begin
				lo = {g16, g16};
				hi = {dv_sb.src_hi[31:16], g16};
			end
			FMT_VUYA8: begin
				lo = {dv_sb.src_lo[31:24], g8, CHROMA_NEUTRAL};
			end
			FMT_ARGB8: begin
				lo = {g8, g8, g8, dv_sb.src_lo[7:0]};
			end
			FMT_ARGB16: begin
				lo = {g16, dv_sb.src_lo[15:0]};
				hi = {g16, g16};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		pixel_out <= '{dst_word_lo: lo, dst_word_hi: hi, last_out: dv_sb.last};
	end

	a_result_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, LAT))
		else $error("result without a matching input transfer");

	a_bad_format_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && fmt_q != FMT_BGRA8 && fmt_q != FMT_BGRA16 && fmt_q != FMT_VUYA8
			&& fmt_q != FMT_ARGB8 && fmt_q != FMT_ARGB16 && $stable(fmt_q))
		|-> (pixel_out.dst_word_lo == '0 && pixel_out.dst_word_hi == '0))
		else $error("undefined format produced nonzero words");

	a_hi_zero_8bit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && $stable(fmt_q)
			&& (fmt_q == FMT_BGRA8 || fmt_q == FMT_VUYA8 || fmt_q == FMT_ARGB8))
		|-> pixel_out.dst_word_hi == '0)
		else $error("second word nonzero in an 8-bit format");

endmodule

### test/gms_pixel_checker.sv
// Checker for the gradient magnitude sketch pixel unit: follows register writes,
// predicts each pixel from its accepted input and compares the result stream.
// Depends on gms_pkg.
`timescale 1ns / 1ps
module gms_pixel_checker #(
	parameter int DIVIDER = 100
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  gms_pkg::pix_in_t                   pixel_in,
	input  logic                               result_valid,
	input  gms_pkg::pix_out_t                  pixel_out,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [gms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gms_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                 outstanding,
	output int                                 mismatches
);
	import gms_pkg::*;

	logic [FMT_W-1:0]  fmt_q;
	logic [GAIN_W-1:0] gain_q;
	pix_out_t          expected_pixels[$];
	pix_out_t          want;
	int                errs;

	function automatic logic [ROOT_W-1:0] floor_root(input logic [2*ROOT_W-1:0] n);
		logic [2*ROOT_W-1:0] rem;
		logic [2*ROOT_W-1:0] res;
		logic [2*ROOT_W-1:0] bitv;
		rem = n;
		res = '0;
		bitv = 1 << (2*ROOT_W-2);
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[ROOT_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] grey_level(input logic signed [GRAD_W-1:0] gv,
			input logic signed [GRAD_W-1:0] gh, input logic [GAIN_W-1:0] g_n,
			input logic [QUO_W-1:0] maxv);
		longint          a;
		longint          b;
		longint unsigned q;
		longint unsigned p;
		longint unsigned den;
		longint unsigned c;
		a = gv;
		b = gh;
		if (a < 0)
			a = -a;
		if (b < 0)
			b = -b;
		q = a * a + b * b;
		p = floor_root(q[2*ROOT_W-1:0]);
		p = p * g_n;
		den = DIVIDER * 256;
		c = (p + den - 1) / den;
		if (c > maxv)
			c = maxv;
		return WORD_W'(maxv - c);
	endfunction

	function automatic pix_out_t sketch_pixel(input pix_in_t px, input logic [FMT_W-1:0] fmt,
			input logic [GAIN_W-1:0] g_n);
		pix_out_t          r;
		logic [WORD_W-1:0] g8;
		logic [WORD_W-1:0] g16;
		g8 = grey_level(px.grad_vertical, px.grad_horizontal, g_n, MAX8);
		g16 = grey_level(px.grad_vertical, px.grad_horizontal, g_n, MAX16);
		r = '0;
		r.last_out = px.frame_last;
		case (fmt)
			FMT_BGRA8: begin
				r.dst_word_lo = g8 | (g8 << 8) | (g8 << 16) | (px.src_word_lo & 32'hFF00_0000);
			end
			FMT_BGRA16: begin
				r.dst_word_lo = g16 | (g16 << 16);
				r.dst_word_hi = g16 | (px.src_word_hi & 32'hFFFF_0000);
			end
			FMT_VUYA8: begin
				r.dst_word_lo = {16'h0, CHROMA_NEUTRAL} | (g8 << 16)
					| (px.src_word_lo & 32'hFF00_0000);
			end
			FMT_ARGB8: begin
				r.dst_word_lo = (px.src_word_lo & 32'h0000_00FF) | (g8 << 8) | (g8 << 16)
					| (g8 << 24);
			end
			FMT_ARGB16: begin
				r.dst_word_lo = (px.src_word_lo & 32'h0000_FFFF) | (g16 << 16);
				r.dst_word_hi = g16 | (g16 << 16);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q = FMT_BGRA8;
			gain_q = GAIN_RESET;
			expected_pixels.delete();
			errs = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (result_valid) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel result with no input pending: lo %h hi %h last %b",
						pixel_out.dst_word_lo, pixel_out.dst_word_hi, pixel_out.last_out);
					errs++;
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out.dst_word_lo !== want.dst_word_lo) begin
						$error("dst_word_lo: expected %h, got %h", want.dst_word_lo,
							pixel_out.dst_word_lo);
						errs++;
					end
					if (pixel_out.dst_word_hi !== want.dst_word_hi) begin
						$error("dst_word_hi: expected %h, got %h", want.dst_word_hi,
							pixel_out.dst_word_hi);
						errs++;
					end
					if (pixel_out.last_out !== want.last_out) begin
						$error("last_out: expected %b, got %b", want.last_out,
							pixel_out.last_out);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PIXEL_FORMAT: fmt_q = cfg_data[FMT_W-1:0];
					CFG_GAIN:         gain_q = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				expected_pixels.push_back(sketch_pixel(pixel_in, fmt_q, gain_q));
			outstanding <= expected_pixels.size();
			mismatches <= errs;
		end
	end

endmodule

### test/tb_gradient_magnitude_sketch_pixel_unit.sv
// Testbench top for the gradient magnitude sketch pixel unit: drives corner and
// random pixels under every format and several gains, and gives the verdict.
// Depends on gms_pkg, gms_pixel_checker and the unit itself.
`timescale 1ns / 1ps
module tb_gradient_magnitude_sketch_pixel_unit;
	import gms_pkg::*;

	localparam int DIVIDER = 100;
	localparam int LATENCY = 27;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PIXELS_PER_PHASE = 120;
	localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
	localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	pix_in_t               pixel_in;
	logic                  result_valid;
	pix_out_t              pixel_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    outstanding;
	int                    mismatches;
	int                    quiet;
	bit                    idle_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gradient_magnitude_sketch_pixel_unit #(
		.DIVIDER(DIVIDER)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_in(pixel_in),
		.result_valid(result_valid),
		.pixel_out(pixel_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gms_pixel_checker #(
		.DIVIDER(DIVIDER)
	) pixel_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_in(pixel_in),
		.result_valid(result_valid),
		.pixel_out(pixel_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic signed [GRAD_W-1:0] random_grad();
		int k;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(0, 1) ? GRAD_MAX : GRAD_MIN;
			2, 3: return GRAD_W'($urandom);
			default: begin
				k = $urandom_range(1, 17);
				return GRAD_W'($urandom_range(0, 2**(k+1) - 1) - 2**k);
			end
		endcase
	endfunction

	function automatic pix_in_t random_pixel();
		pix_in_t px;
		px.grad_vertical = random_grad();
		px.grad_horizontal = random_grad();
		px.src_word_lo = $urandom;
		px.src_word_hi = $urandom;
		px.frame_last = 1'($urandom_range(0, 1));
		return px;
	endfunction

	function automatic pix_in_t corner_pixel(input int k);
		pix_in_t px;
		px.src_word_lo = k[0] ? 32'hFFFF_FFFF : $urandom;
		px.src_word_hi = k[0] ? $urandom : 32'hFFFF_FFFF;
		px.frame_last = k[1];
		case (k)
			0: begin px.grad_vertical = '0;        px.grad_horizontal = '0;        end
			1: begin px.grad_vertical = GRAD_MAX;  px.grad_horizontal = GRAD_MAX;  end
			2: begin px.grad_vertical = GRAD_MIN;  px.grad_horizontal = GRAD_MIN;  end
			3: begin px.grad_vertical = GRAD_MIN;  px.grad_horizontal = GRAD_MAX;  end
			4: begin px.grad_vertical = 20'sd1;    px.grad_horizontal = '0;        end
			5: begin px.grad_vertical = '0;        px.grad_horizontal = -20'sd1;   end
			6: begin px.grad_vertical = 20'sd65280; px.grad_horizontal = '0;       end
			default: begin px.grad_vertical = -20'sd65281; px.grad_horizontal = '0; end
		endcase
		return px;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input int fmt, input int gain);
		write_reg(CFG_PIXEL_FORMAT, ($urandom << FMT_W) | fmt);
		write_reg(CFG_GAIN, ($urandom << GAIN_W) | gain);
		write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_GAIN + 1)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input pix_in_t px);
		while (idle_on && $urandom_range(0, 99) < 38) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel_in <= px;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int fmt;
		int gain;
		arst_n = 1'b0;
		start = 1'b0;
		pixel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int f = 0; f < 2**FMT_W; f++) begin
			if (f > 0)
				drain();
			gain = (f == FMT_VUYA8) ? 0 : (f == FMT_ARGB16) ? 2**GAIN_W - 1 : GAIN_RESET;
			configure(f, gain);
			for (int k = 0; k < 3; k++)
				send_pixel(corner_pixel((3*f + k) % 8));
			start <= 1'b0;
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			fmt = (p < 2**FMT_W) ? p : $urandom_range(0, FMT_ARGB16);
			case (p % 5)
				0: gain = 0;
				1: gain = 2**GAIN_W - 1;
				2: gain = 1;
				3: gain = GAIN_RESET;
				default: gain = $urandom_range(0, 2**GAIN_W - 1);
			endcase
			configure(fmt, gain);
			idle_on = (p != 5);
			repeat (PIXELS_PER_PHASE)
				send_pixel(random_pixel());
			start <= 1'b0;
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
hw/rtl/gms_pkg.sv
hw/rtl/gms_isqrt.sv
hw/rtl/gms_cdiv.sv
hw/rtl/gradient_magnitude_sketch_pixel_unit.sv
test/gms_pixel_checker.sv
test/tb_gradient_magnitude_sketch_pixel_unit.sv
